// ===== rtl/sbsi_pkg.sv =====
// Shared types, widths and helpers for the segment/box slab intersection pipeline.
// Used by every module of the block; depends on nothing.
package sbsi_pkg;

  localparam int CW   = 32;              // coordinate width
  localparam int DW   = CW + 1;          // difference width (signed)
  localparam int SQW  = 2 * DW - 1;      // square of a difference magnitude
  localparam int SUMW = SQW + 2;         // sum of three squares
  localparam int RW   = (SUMW + 1) / 2;  // square root width
  localparam int VW   = 2 * RW;          // radicand padded to an even width
  localparam int REMW = RW + 2;          // root remainder width
  localparam int PW   = DW + RW;         // distance numerator product width
  localparam int TW   = 64;              // signed distance width
  localparam int OW   = 31;              // output distance width
  localparam int DIV_LAT = PW + 1;       // divider stages: product stage plus one per quotient bit

  localparam logic signed [TW-1:0] T_SAT   = 64'sh4000_0000_0000_0000;
  localparam logic signed [TW-1:0] OUT_MAX = 64'sh0000_0000_7FFF_FFFF;

  typedef enum logic [1:0] {
    AX_DIV   = 2'd0,   // normal axis, both distances from the divider
    AX_FREE  = 2'd1,   // parallel axis, start inside the slab
    AX_BELOW = 2'd2,   // parallel axis, start below the slab
    AX_ABOVE = 2'd3    // parallel axis, start above the slab
  } axis_cls_t;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;
    logic signed [CW-1:0] box_x_min;
    logic signed [CW-1:0] box_x_max;
    logic signed [CW-1:0] box_y_min;
    logic signed [CW-1:0] box_y_max;
    logic signed [CW-1:0] box_z_min;
    logic signed [CW-1:0] box_z_max;
  } seg_t;

  typedef struct packed {
    logic          hit;
    logic [OW-1:0] entry_dist;
    logic [OW-1:0] exit_dist;
    logic          degenerate;
  } res_t;

  typedef struct packed {
    logic signed [DW-1:0] num_lo;
    logic signed [DW-1:0] num_hi;
    logic signed [DW-1:0] dir;
    axis_cls_t            cls;
  } axis_t;

  typedef struct packed {
    axis_t [2:0] ax;
  } side_t;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    logic [DW-1:0] m;
    m = v[DW-1] ? DW'(-v) : DW'(v);
    return m;
  endfunction

endpackage

// ===== rtl/sbsi_front.sv =====
// Front end: per-axis differences and slab class, squares, sum of squares.
// Three register stages; uses sbsi_pkg.
module sbsi_front import sbsi_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  seg_t            seg,
  output logic            out_vld,
  output logic [SUMW-1:0] out_sum,
  output side_t           out_side
);

  logic signed [CW-1:0] s_c [3];
  logic signed [CW-1:0] e_c [3];
  logic signed [CW-1:0] bmin_c [3];
  logic signed [CW-1:0] bmax_c [3];
  side_t                side1_next;

  logic            v1, v2;
  side_t           side1, side2;
  logic [SQW-1:0]  sq2 [3];

  always_comb begin
    s_c[0] = seg.start_x; s_c[1] = seg.start_y; s_c[2] = seg.start_z;
    e_c[0] = seg.end_x;   e_c[1] = seg.end_y;   e_c[2] = seg.end_z;
    bmin_c[0] = seg.box_x_min; bmax_c[0] = seg.box_x_max;
    bmin_c[1] = seg.box_y_min; bmax_c[1] = seg.box_y_max;
    bmin_c[2] = seg.box_z_min; bmax_c[2] = seg.box_z_max;
    for (int a = 0; a < 3; a++) begin
      logic signed [CW-1:0] lo, hi;
      lo = (bmin_c[a] < bmax_c[a]) ? bmin_c[a] : bmax_c[a];
      hi = (bmin_c[a] < bmax_c[a]) ? bmax_c[a] : bmin_c[a];
      side1_next.ax[a].dir    = DW'(e_c[a]) - DW'(s_c[a]);
      side1_next.ax[a].num_lo = DW'(bmin_c[a]) - DW'(s_c[a]);
      side1_next.ax[a].num_hi = DW'(bmax_c[a]) - DW'(s_c[a]);
      if (e_c[a] != s_c[a]) begin
        side1_next.ax[a].cls = AX_DIV;
      end else if (s_c[a] < lo) begin
        side1_next.ax[a].cls = AX_BELOW;
      end else if (s_c[a] > hi) begin
        side1_next.ax[a].cls = AX_ABOVE;
      end else begin
        side1_next.ax[a].cls = AX_FREE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      out_vld <= v2;
    end
    if (en) begin
      side1 <= side1_next;
      side2 <= side1;
      out_side <= side2;
      for (int a = 0; a < 3; a++) begin
        sq2[a] <= SQW'(mag(side1.ax[a].dir)) * SQW'(mag(side1.ax[a].dir));
      end
      out_sum <= SUMW'(sq2[0]) + SUMW'(sq2[1]) + SUMW'(sq2[2]);
    end
  end

endmodule

// ===== rtl/sbsi_isqrt.sv =====
// Pipelined floor square root, one root bit per stage, side data carried along.
// Uses sbsi_pkg.
module sbsi_isqrt import sbsi_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [SUMW-1:0] in_val,
  input  side_t           in_side,
  output logic            out_vld,
  output logic [RW-1:0]   out_root,
  output side_t           out_side
);

  logic            st_v    [RW];
  logic [REMW-1:0] st_rem  [RW];
  logic [RW-1:0]   st_root [RW];
  logic [VW-1:0]   st_val  [RW];
  side_t           st_side [RW];

  for (genvar j = 0; j < RW; j++) begin : g_it
    logic            v_i;
    logic [REMW-1:0] rem_i;
    logic [RW-1:0]   root_i;
    logic [VW-1:0]   val_i;
    side_t           side_i;
    logic [REMW+1:0] cur, trial, diff;
    logic            ge;

    if (j == 0) begin : g_first
      assign v_i    = in_vld;
      assign rem_i  = '0;
      assign root_i = '0;
      assign val_i  = VW'(in_val);
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = st_v[j-1];
      assign rem_i  = st_rem[j-1];
      assign root_i = st_root[j-1];
      assign val_i  = st_val[j-1];
      assign side_i = st_side[j-1];
    end

    assign cur   = {rem_i, val_i[VW-1 -: 2]};
    assign trial = {2'b00, root_i, 2'b01};
    assign diff  = cur - trial;
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[j] <= 1'b0;
      end else if (en) begin
        st_v[j] <= v_i;
      end
      if (en) begin
        st_rem[j]  <= ge ? diff[REMW-1:0] : cur[REMW-1:0];
        st_root[j] <= {root_i[RW-2:0], ge};
        st_val[j]  <= {val_i[VW-3:0], 2'b00};
        st_side[j] <= side_i;
      end
    end
  end

  assign out_vld  = st_v[RW-1];
  assign out_root = st_root[RW-1];
  assign out_side = st_side[RW-1];

endmodule

// ===== rtl/sbsi_div.sv =====
// Distance divider: product stage, then restoring division one quotient bit per stage.
// Payload only; the caller tracks valid. Uses sbsi_pkg.
module sbsi_div import sbsi_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] num,
  input  logic [RW-1:0] len,
  input  logic [DW-1:0] den,
  output logic [PW-1:0] quot
);

  logic [PW-1:0] prod;
  logic [DW-1:0] den0;

  logic [DW-1:0] st_rem [PW];
  logic [PW-1:0] st_dvd [PW];
  logic [PW-1:0] st_q   [PW];
  logic [DW-1:0] st_den [PW];

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'(num) * PW'(len);
      den0 <= den;
    end
  end

  for (genvar j = 0; j < PW; j++) begin : g_it
    logic [DW-1:0] rem_i, den_i;
    logic [PW-1:0] dvd_i, q_i;
    logic [DW:0]   cur, diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_i = '0;
      assign dvd_i = prod;
      assign q_i   = '0;
      assign den_i = den0;
    end else begin : g_next
      assign rem_i = st_rem[j-1];
      assign dvd_i = st_dvd[j-1];
      assign q_i   = st_q[j-1];
      assign den_i = st_den[j-1];
    end

    assign cur  = {rem_i, dvd_i[PW-1]};
    assign ge   = (cur >= {1'b0, den_i});
    assign diff = cur - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[j] <= ge ? diff[DW-1:0] : cur[DW-1:0];
        st_dvd[j] <= {dvd_i[PW-2:0], 1'b0};
        st_q[j]   <= {q_i[PW-2:0], ge};
        st_den[j] <= den_i;
      end
    end
  end

  assign quot = st_q[PW-1];

endmodule

// ===== rtl/sbsi_back.sv =====
// Back end: signed slab distances, entry/exit reduction, saturation, result register.
// Three register stages, the last is the output register; uses sbsi_pkg.
module sbsi_back import sbsi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic [5:0][PW-1:0]  quot,
  input  side_t               side,
  input  logic [RW-1:0]       len,
  output logic                out_vld,
  output res_t                res
);

  function automatic logic signed [TW-1:0] sdist(input logic [PW-1:0] q, input logic neg);
    logic [TW-1:0] m;
    m = (q > PW'(T_SAT)) ? T_SAT : TW'(q);
    return neg ? -m : m;
  endfunction

  logic                   v1, v2;
  logic signed [TW-1:0]   near1 [3];
  logic signed [TW-1:0]   far1  [3];
  logic [2:0]             use1;
  logic [RW-1:0]          len1;
  logic                   degen1, degen2;
  logic signed [TW-1:0]   tmin2, tmax2;

  logic signed [TW-1:0]   near_c [3];
  logic signed [TW-1:0]   far_c  [3];
  logic [2:0]             use_c;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [TW-1:0] ta, tb;
      ta = sdist(quot[2*a],   side.ax[a].num_lo[DW-1] ^ side.ax[a].dir[DW-1]);
      tb = sdist(quot[2*a+1], side.ax[a].num_hi[DW-1] ^ side.ax[a].dir[DW-1]);
      use_c[a] = 1'b1;
      case (side.ax[a].cls)
        AX_BELOW: begin ta = T_SAT; tb = T_SAT; end
        AX_ABOVE: begin ta = -T_SAT; tb = -T_SAT; end
        AX_FREE:  use_c[a] = 1'b0;
        default:  ;
      endcase
      near_c[a] = (ta < tb) ? ta : tb;
      far_c[a]  = (ta < tb) ? tb : ta;
    end
  end

  // Unused axes fall back to the neutral bounds 0 and len.
  logic signed [TW-1:0] n_c [3];
  logic signed [TW-1:0] f_c [3];
  logic signed [TW-1:0] lenw, mx01, mx2, mn01, mn2;

  always_comb begin
    lenw = TW'(len1);
    for (int a = 0; a < 3; a++) begin
      n_c[a] = use1[a] ? near1[a] : '0;
      f_c[a] = use1[a] ? far1[a]  : lenw;
    end
    mx01 = (n_c[0] > n_c[1]) ? n_c[0] : n_c[1];
    mx2  = (n_c[2] > 0) ? n_c[2] : '0;
    mn01 = (f_c[0] < f_c[1]) ? f_c[0] : f_c[1];
    mn2  = (f_c[2] < lenw) ? f_c[2] : lenw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      out_vld <= v2;
    end
    if (en) begin
      near1  <= near_c;
      far1   <= far_c;
      use1   <= use_c;
      len1   <= len;
      degen1 <= (len == '0);

      tmin2  <= (mx01 > mx2) ? mx01 : mx2;
      tmax2  <= (mn01 < mn2) ? mn01 : mn2;
      degen2 <= degen1;

      res.degenerate <= degen2;
      res.hit        <= !degen2 && (tmin2 <= tmax2);
      res.entry_dist <= degen2 ? '0 :
                        (tmin2 > OUT_MAX) ? OW'(OUT_MAX) : tmin2[OW-1:0];
      res.exit_dist  <= (degen2 || tmax2 < 0) ? '0 :
                        (tmax2 > OUT_MAX) ? OW'(OUT_MAX) : tmax2[OW-1:0];
    end
  end

endmodule

// ===== rtl/segment_box_slab_intersect.sv =====
// Segment versus axis-aligned box slab test, Q16.16, fully pipelined.
// Register stages from seg transfer to res valid: 3 front, 34 square root, 68 divider,
// 3 back; throughput one item per cycle while res is not stalled, every step is its own stage.
// The whole pipeline holds while res is stalled; bubbles are not squeezed out.
// Synchronous reset clears all valid bits; payload registers are not reset.
module segment_box_slab_intersect import sbsi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic seg_valid,
  output logic seg_stall,
  input  seg_t seg,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  logic            en;
  logic            f_vld;
  logic [SUMW-1:0] f_sum;
  side_t           f_side;
  logic            r_vld;
  logic [RW-1:0]   r_len;
  side_t           r_side;
  logic [5:0][PW-1:0] quot;

  logic            dl_v    [DIV_LAT];
  side_t           dl_side [DIV_LAT];
  logic [RW-1:0]   dl_len  [DIV_LAT];

  assign en        = !(res_valid && res_stall);
  assign seg_stall = res_valid && res_stall;

  sbsi_front u_front (
    .clk, .rst, .en,
    .in_vld(seg_valid), .seg,
    .out_vld(f_vld), .out_sum(f_sum), .out_side(f_side)
  );

  sbsi_isqrt u_isqrt (
    .clk, .rst, .en,
    .in_vld(f_vld), .in_val(f_sum), .in_side(f_side),
    .out_vld(r_vld), .out_root(r_len), .out_side(r_side)
  );

  for (genvar a = 0; a < 3; a++) begin : g_axis
    sbsi_div u_div_lo (
      .clk, .en,
      .num(mag(r_side.ax[a].num_lo)), .len(r_len), .den(mag(r_side.ax[a].dir)),
      .quot(quot[2*a])
    );
    sbsi_div u_div_hi (
      .clk, .en,
      .num(mag(r_side.ax[a].num_hi)), .len(r_len), .den(mag(r_side.ax[a].dir)),
      .quot(quot[2*a+1])
    );
  end

  // Carry valid, side data and length alongside the dividers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) dl_v[i] <= 1'b0;
    end else if (en) begin
      dl_v[0] <= r_vld;
      for (int i = 1; i < DIV_LAT; i++) dl_v[i] <= dl_v[i-1];
    end
    if (en) begin
      dl_side[0] <= r_side;
      dl_len[0]  <= r_len;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl_side[i] <= dl_side[i-1];
        dl_len[i]  <= dl_len[i-1];
      end
    end
  end

  sbsi_back u_back (
    .clk, .rst, .en,
    .in_vld(dl_v[DIV_LAT-1]), .quot,
    .side(dl_side[DIV_LAT-1]), .len(dl_len[DIV_LAT-1]),
    .out_vld(res_valid), .res
  );

endmodule

// ===== rtl/sbsi_check.sv =====
// Port-level checker for segment_box_slab_intersect, attached by bind.
// Uses sbsi_pkg.
module sbsi_check import sbsi_pkg::*; (
  input logic clk,
  input logic rst,
  input logic seg_valid,
  input logic seg_stall,
  input seg_t seg,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.degenerate |->
      !res.hit && res.entry_dist == '0 && res.exit_dist == '0)
    else $error("degenerate result carries a hit or distances");

  a_order: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.hit |-> res.entry_dist <= res.exit_dist)
    else $error("hit with entry beyond exit");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

endmodule

bind segment_box_slab_intersect sbsi_check u_check (.*);
